>>> rtl/u8te_pkg.sv
// Shared types and constants of the UTF-8 weighted token estimator.
package u8te_pkg;

  // Fixed field widths
  localparam int WEIGHT_W   = 10;
  localparam int BUDGET_W   = 22;
  localparam int EST_W      = 22;
  localparam int NBYTES_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = BUDGET_W;

  localparam logic [EST_W-1:0] EST_MAX = '1;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_CJK_WEIGHT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OTHER_WEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_BUDGET = 2'd2;

  localparam logic [WEIGHT_W-1:0] CJK_WEIGHT_RST   = 10'd256;
  localparam logic [WEIGHT_W-1:0] OTHER_WEIGHT_RST = 10'd64;
  localparam logic [BUDGET_W-1:0] TOKEN_BUDGET_RST = '0;

  // Depth of the queue between decoder and accumulator, a power of two
  localparam int FIFO_DEPTH = 4;

  typedef enum logic [1:0] {
    UNIT_NONE,
    UNIT_CJK,
    UNIT_OTHER,
    UNIT_QUARTER
  } unit_kind_e;

  // One queued work item for the accumulator
  typedef struct packed {
    unit_kind_e          kind;
    logic [NBYTES_W-1:0] nbytes;
    logic                byte_inc;
    logic                last;
  } entry_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] cjk_weight;
    logic [WEIGHT_W-1:0] other_weight;
    logic [BUDGET_W-1:0] token_budget;
  } cfg_t;

endpackage

>>> rtl/u8te_front.sv
// Byte decoder: lead-byte UTF-8 decode, CJK classification and end-of-text fixup.
module u8te_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [7:0]       text_byte_i,
  input  logic             is_last_i,
  output logic             in_stall_o,
  output logic             push_valid_o,
  output u8te_pkg::entry_t push_entry_o,
  input  logic             fifo_full_i
);
  import u8te_pkg::*;

  localparam int CP_W    = 21;
  localparam int TAIL_N  = 3;
  localparam int CJK_N   = 9;

  localparam logic [NBYTES_W-1:0] LEN_BAD = 3'd0;
  localparam logic [NBYTES_W-1:0] LEN1    = 3'd1;
  localparam logic [NBYTES_W-1:0] LEN2    = 3'd2;
  localparam logic [NBYTES_W-1:0] LEN3    = 3'd3;
  localparam logic [NBYTES_W-1:0] LEN4    = 3'd4;

  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;

  localparam logic [CP_W-1:0] CJK_LO [CJK_N] = '{
    21'h02E80, 21'h03000, 21'h03040, 21'h03400, 21'h04E00,
    21'h0AC00, 21'h0F900, 21'h0FF00, 21'h20000
  };
  localparam logic [CP_W-1:0] CJK_HI [CJK_N] = '{
    21'h02FDF, 21'h0303F, 21'h030FF, 21'h04DBF, 21'h09FFF,
    21'h0D7AF, 21'h0FAFF, 21'h0FFEF, 21'h2A6DF
  };

  function automatic logic [NBYTES_W-1:0] lead_len(input logic [7:0] b);
    logic [NBYTES_W-1:0] len;
    priority if (b[7] == 1'b0)                   len = LEN1;
    else if ((b & LEAD2_MASK) == LEAD2_CODE)     len = LEN2;
    else if ((b & LEAD3_MASK) == LEAD3_CODE)     len = LEN3;
    else if ((b & LEAD4_MASK) == LEAD4_CODE)     len = LEN4;
    else                                         len = LEN_BAD;
    return len;
  endfunction

  function automatic logic [CP_W-1:0] lead_bits(input logic [7:0] b,
                                                input logic [NBYTES_W-1:0] len);
    logic [CP_W-1:0] c;
    unique case (len)
      LEN2:    c = CP_W'(b & 8'h1F);
      LEN3:    c = CP_W'(b & 8'h0F);
      LEN4:    c = CP_W'(b & 8'h07);
      default: c = CP_W'(b);
    endcase
    return c;
  endfunction

  function automatic logic in_cjk(input logic [CP_W-1:0] c);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < CJK_N; i++) begin
      if (c >= CJK_LO[i] && c <= CJK_HI[i]) hit = 1'b1;
    end
    return hit;
  endfunction

  // A byte standing alone at the end of a text: ASCII is a code point, else a fragment
  function automatic unit_kind_e single_kind(input logic [7:0] b);
    return (lead_len(b) == LEN1) ? UNIT_OTHER : UNIT_QUARTER;
  endfunction

  logic [1:0]          pend_cnt_q, pend_cnt_d;
  logic [NBYTES_W-1:0] seq_len_q, seq_len_d;
  logic [CP_W-1:0]     cp_q, cp_d;
  logic [7:0]          pend1_q, pend1_d;
  logic [7:0]          pend2_q, pend2_d;
  logic [1:0]          tail_left_q;
  entry_t              tail_q [TAIL_N];

  logic [NBYTES_W-1:0] len;
  logic [CP_W-1:0]     cp_next;
  logic                seq_done;
  entry_t              main_entry;
  entry_t              tail_plan [TAIL_N];
  entry_t              tail_out;
  logic [1:0]          tail_cnt;
  logic                has_tail;
  logic                accept;
  logic                tail_emit;

  assign in_stall_o = (tail_left_q != 2'd0) || fifo_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign tail_emit  = (tail_left_q != 2'd0) && !fifo_full_i;

  always_comb begin
    len        = lead_len(text_byte_i);
    cp_next    = {cp_q[CP_W-7:0], text_byte_i[5:0]};
    seq_done   = ({1'b0, pend_cnt_q} + 3'd1) >= seq_len_q;
    main_entry = '{kind: UNIT_NONE, nbytes: LEN1, byte_inc: 1'b1, last: 1'b0};
    pend_cnt_d = pend_cnt_q;
    seq_len_d  = seq_len_q;
    cp_d       = cp_q;
    pend1_d    = pend1_q;
    pend2_d    = pend2_q;

    if (pend_cnt_q == 2'd0) begin
      unique case (len)
        LEN_BAD: main_entry.kind = UNIT_QUARTER;
        LEN1:    main_entry.kind = UNIT_OTHER;
        default: begin
          seq_len_d  = len;
          cp_d       = lead_bits(text_byte_i, len);
          pend_cnt_d = 2'd1;
        end
      endcase
    end else if (seq_done) begin
      main_entry.kind   = in_cjk(cp_next) ? UNIT_CJK : UNIT_OTHER;
      main_entry.nbytes = seq_len_q;
      pend_cnt_d        = 2'd0;
      seq_len_d         = '0;
      cp_d              = '0;
    end else begin
      if (pend_cnt_q == 2'd1) begin
        pend1_d = text_byte_i;
      end else begin
        pend2_d = text_byte_i;
      end
      pend_cnt_d = pend_cnt_q + 2'd1;
      cp_d       = cp_next;
    end

    // Text cut inside a sequence: lead byte counts a quarter, held bytes are rescanned
    for (int i = 0; i < TAIL_N; i++) begin
      tail_plan[i] = '{kind: UNIT_QUARTER, nbytes: LEN1, byte_inc: 1'b0, last: 1'b0};
    end
    tail_cnt = 2'd1;
    unique case (pend_cnt_d)
      2'd2: begin
        tail_plan[1].kind = single_kind(pend1_d);
        tail_cnt          = 2'd2;
      end
      2'd3: begin
        if (lead_len(pend1_d) == LEN2) begin
          tail_plan[1].kind   = UNIT_OTHER;
          tail_plan[1].nbytes = LEN2;
          tail_cnt            = 2'd2;
        end else begin
          tail_plan[1].kind = single_kind(pend1_d);
          tail_plan[2].kind = single_kind(pend2_d);
          tail_cnt          = 2'd3;
        end
      end
      default: ;
    endcase
    has_tail        = pend_cnt_d != 2'd0;
    main_entry.last = is_last_i && !has_tail;

    tail_out      = tail_q[0];
    tail_out.last = tail_left_q == 2'd1;
  end

  assign push_valid_o = accept || tail_emit;
  assign push_entry_o = accept ? main_entry : tail_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_cnt_q  <= 2'd0;
      seq_len_q   <= '0;
      cp_q        <= '0;
      tail_left_q <= 2'd0;
    end else if (accept) begin
      if (is_last_i) begin
        pend_cnt_q  <= 2'd0;
        seq_len_q   <= '0;
        cp_q        <= '0;
        tail_left_q <= has_tail ? tail_cnt : 2'd0;
      end else begin
        pend_cnt_q <= pend_cnt_d;
        seq_len_q  <= seq_len_d;
        cp_q       <= cp_d;
      end
    end else if (tail_emit) begin
      tail_left_q <= tail_left_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend1_q <= pend1_d;
      pend2_q <= pend2_d;
      if (is_last_i && has_tail) begin
        for (int i = 0; i < TAIL_N; i++) begin
          tail_q[i] <= tail_plan[i];
        end
      end
    end else if (tail_emit) begin
      // advance the fixup list
      for (int i = 0; i < TAIL_N - 1; i++) begin
        tail_q[i] <= tail_q[i+1];
      end
    end
  end

endmodule

>>> rtl/u8te_fifo.sv
// Short queue of decoded work items between the decoder and the accumulator.
module u8te_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  u8te_pkg::entry_t push_entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output u8te_pkg::entry_t pop_entry_o,
  output logic             valid_o
);
  import u8te_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [PTR_W:0]   count_q;
  entry_t           mem_q [FIFO_DEPTH];

  assign full_o      = count_q == (PTR_W+1)'(FIFO_DEPTH);
  assign valid_o     = count_q != '0;
  assign pop_entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_entry_i;
  end

endmodule

>>> rtl/u8te_back.sv
// Accumulator: weighted sum, byte counts, budget cut and the result register.
module u8te_back #(
  parameter  int MAX_TEXT_BYTES       = 1048576,
  parameter  int WEIGHT_FRACTION_BITS = 8,
  localparam int CNT_W                = $clog2(MAX_TEXT_BYTES + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  u8te_pkg::cfg_t             cfg_i,
  input  logic                       entry_valid_i,
  input  u8te_pkg::entry_t           entry_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [u8te_pkg::EST_W-1:0] token_estimate_o,
  output logic [CNT_W-1:0]           total_bytes_o,
  output logic [CNT_W-1:0]           kept_bytes_o,
  output logic                       was_truncated_o
);
  import u8te_pkg::*;

  localparam int SUM_W = EST_W + WEIGHT_FRACTION_BITS;
  localparam int INC_W = (WEIGHT_FRACTION_BITS - 1 > WEIGHT_W) ?
                         WEIGHT_FRACTION_BITS - 1 : WEIGHT_W;
  localparam logic [INC_W-1:0] QUARTER_INC = INC_W'(1) << (WEIGHT_FRACTION_BITS - 2);
  localparam logic [SUM_W-1:0] HALF_INC    = SUM_W'(1) << (WEIGHT_FRACTION_BITS - 1);
  localparam logic [SUM_W-1:0] SUM_MAX     = '1;
  localparam logic [CNT_W-1:0] MAX_CNT     = CNT_W'(MAX_TEXT_BYTES);

  logic [SUM_W-1:0] sum_q, sum_b, sum_d;
  logic [CNT_W-1:0] total_q, total_b, total_d;
  logic [CNT_W-1:0] cut_q, cut_b, cut_d;
  logic             hit_q, hit_b, hit_d;
  logic             fin_q, fin_d;
  logic             out_valid_q;

  logic             out_free;
  logic             fin_clear;
  logic             pop;
  logic [INC_W-1:0] inc;
  logic             has_unit;
  logic [SUM_W:0]   sum_plus;
  logic [SUM_W-1:0] limit;
  logic [CNT_W:0]   cut_plus;
  logic [SUM_W:0]   est_full;
  logic [EST_W:0]   est_top;
  logic [EST_W-1:0] est;
  logic             trunc;

  assign out_free  = !out_valid_q || !out_stall_i;
  // Result leaves the accumulator this cycle; the next text starts from zero
  assign fin_clear = fin_q && out_free;
  assign pop       = entry_valid_i && (!fin_q || out_free);
  assign pop_o     = pop;

  assign sum_b   = fin_clear ? '0   : sum_q;
  assign total_b = fin_clear ? '0   : total_q;
  assign cut_b   = fin_clear ? '0   : cut_q;
  assign hit_b   = fin_clear ? 1'b0 : hit_q;

  always_comb begin
    unique case (entry_i.kind)
      UNIT_CJK:     inc = INC_W'(cfg_i.cjk_weight);
      UNIT_OTHER:   inc = INC_W'(cfg_i.other_weight);
      UNIT_QUARTER: inc = QUARTER_INC;
      default:      inc = '0;
    endcase
    has_unit = entry_i.kind != UNIT_NONE;
    sum_plus = {1'b0, sum_b} + (SUM_W+1)'(inc);
    limit    = {cfg_i.token_budget, {WEIGHT_FRACTION_BITS{1'b0}}};
    cut_plus = {1'b0, cut_b} + (CNT_W+1)'(entry_i.nbytes);

    sum_d   = sum_b;
    total_d = total_b;
    cut_d   = cut_b;
    hit_d   = hit_b;
    if (pop) begin
      if (entry_i.byte_inc && total_b < MAX_CNT) total_d = total_b + CNT_W'(1);
      if (has_unit) begin
        if (!hit_b) begin
          if (sum_plus > {1'b0, limit}) begin
            hit_d = 1'b1;
          end else begin
            cut_d = (cut_plus > {1'b0, MAX_CNT}) ? MAX_CNT : cut_plus[CNT_W-1:0];
          end
        end
        sum_d = sum_plus[SUM_W] ? SUM_MAX : sum_plus[SUM_W-1:0];
      end
    end
    fin_d = pop ? entry_i.last : (fin_q && !fin_clear);

    // Round half up and saturate
    est_full = {1'b0, sum_q} + (SUM_W+1)'(HALF_INC);
    est_top  = est_full[SUM_W:WEIGHT_FRACTION_BITS];
    est      = est_top[EST_W] ? EST_MAX : est_top[EST_W-1:0];
    trunc    = (cfg_i.token_budget != '0) && hit_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      total_q     <= '0;
      cut_q       <= '0;
      hit_q       <= 1'b0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      total_q     <= total_d;
      cut_q       <= cut_d;
      hit_q       <= hit_d;
      fin_q       <= fin_d;
      out_valid_q <= fin_clear || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_clear) begin
      token_estimate_o <= est;
      total_bytes_o    <= total_q;
      kept_bytes_o     <= trunc ? cut_q : total_q;
      was_truncated_o  <= trunc;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/utf8_weighted_token_estimator.sv
// Top level of the UTF-8 weighted token estimator.
// Takes one text byte per cycle on a valid/stall channel and reports, on the
// byte marked last, the rounded token estimate, the byte count and the prefix
// length that fits the token budget. Bytes are decoded by lead byte only; a
// queue of four work items separates the decoder from the accumulator, so
// either side can stall without stopping the other. Sustained rate is one
// byte per cycle while in_stall_o stays low. A text that ends inside a
// multibyte sequence holds the input while the decoder queues the fixup
// items for the held bytes, and longer while the queue is full. The result
// passes through the queue and the accumulator into an output register and
// waits there while out_stall_i is high. The user must write the
// configuration registers only while no text is in flight; the block
// itself does not enforce it.
module utf8_weighted_token_estimator #(
  parameter  int MAX_TEXT_BYTES       = 1048576,
  parameter  int WEIGHT_FRACTION_BITS = 8,
  localparam int CNT_W                = $clog2(MAX_TEXT_BYTES + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      text_byte_i,
  input  logic                            is_last_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [u8te_pkg::EST_W-1:0]      token_estimate_o,
  output logic [CNT_W-1:0]                total_bytes_o,
  output logic [CNT_W-1:0]                kept_bytes_o,
  output logic                            was_truncated_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [u8te_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [u8te_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import u8te_pkg::*;

  cfg_t   cfg_q;
  logic   push_valid;
  entry_t push_entry;
  logic   fifo_full;
  logic   fifo_valid;
  entry_t fifo_entry;
  logic   pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cjk_weight   <= CJK_WEIGHT_RST;
      cfg_q.other_weight <= OTHER_WEIGHT_RST;
      cfg_q.token_budget <= TOKEN_BUDGET_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_CJK_WEIGHT:   cfg_q.cjk_weight   <= cfg_data_i[WEIGHT_W-1:0];
        CFG_OTHER_WEIGHT: cfg_q.other_weight <= cfg_data_i[WEIGHT_W-1:0];
        CFG_TOKEN_BUDGET: cfg_q.token_budget <= cfg_data_i[BUDGET_W-1:0];
        default: ;
      endcase
    end
  end

  u8te_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .text_byte_i  (text_byte_i),
    .is_last_i    (is_last_i),
    .in_stall_o   (in_stall_o),
    .push_valid_o (push_valid),
    .push_entry_o (push_entry),
    .fifo_full_i  (fifo_full)
  );

  u8te_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_valid),
    .push_entry_i (push_entry),
    .full_o       (fifo_full),
    .pop_i        (pop),
    .pop_entry_o  (fifo_entry),
    .valid_o      (fifo_valid)
  );

  u8te_back #(
    .MAX_TEXT_BYTES       (MAX_TEXT_BYTES),
    .WEIGHT_FRACTION_BITS (WEIGHT_FRACTION_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .entry_valid_i    (fifo_valid),
    .entry_i          (fifo_entry),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .token_estimate_o (token_estimate_o),
    .total_bytes_o    (total_bytes_o),
    .kept_bytes_o     (kept_bytes_o),
    .was_truncated_o  (was_truncated_o)
  );

endmodule

>>> rtl/u8te_checker.sv
// Port-level checks on the result channel of the token estimator, bound to the top level.
module u8te_checker #(
  parameter  int MAX_TEXT_BYTES = 1048576,
  localparam int CNT_W          = $clog2(MAX_TEXT_BYTES + 1)
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_i,
  input logic                       out_stall_i,
  input logic [u8te_pkg::EST_W-1:0] token_estimate_i,
  input logic [CNT_W-1:0]           total_bytes_i,
  input logic [CNT_W-1:0]           kept_bytes_i,
  input logic                       was_truncated_i
);
  import u8te_pkg::*;

  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  a_payload_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> $stable(token_estimate_i) && $stable(total_bytes_i)
                                   && $stable(kept_bytes_i) && $stable(was_truncated_i))
    else $error("result item changed while stalled");

  a_kept_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> kept_bytes_i <= total_bytes_i)
    else $error("kept prefix longer than text");

  a_untrunc_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !was_truncated_i |-> kept_bytes_i == total_bytes_i)
    else $error("untruncated text does not keep every byte");

  a_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> total_bytes_i != '0)
    else $error("result item for a text without bytes");

endmodule

bind utf8_weighted_token_estimator u8te_checker #(
  .MAX_TEXT_BYTES (MAX_TEXT_BYTES)
) u_u8te_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .token_estimate_i (token_estimate_o),
  .total_bytes_i    (total_bytes_o),
  .kept_bytes_i     (kept_bytes_o),
  .was_truncated_i  (was_truncated_o)
);
